@@ design/mme_pkg.sv @@
// Shared types and constants of the matrix multiply engine.
`timescale 1ns / 1ps
`default_nettype none

package mme_pkg;

    // Fixed field widths of the channels.
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 3;
    localparam int VAL_W   = 16;
    localparam int DOT_W   = 35;
    localparam int DIM_W   = 4;
    localparam int CFG_A_W = 2;

    // Command codes of an input word.
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_A = 2'd0,
        CMD_WRITE_B = 2'd1,
        CMD_COMPUTE = 2'd2
    } t_cmd;

    // Configuration register indexes.
    localparam logic [CFG_A_W-1:0] REG_A_ROWS     = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_SHARED_DIM = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_B_COLS     = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    // Tag that travels with each multiply-accumulate step down the pipeline.
    typedef struct packed {
        logic             first;
        logic             last_k;
        logic             last_entry;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

endpackage

`default_nettype wire

@@ design/mme_if.sv @@
// Channel interfaces of the matrix multiply engine: input, result and configuration.
`timescale 1ns / 1ps
`default_nettype none

interface mme_in_if import mme_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] row_sel;
    logic [IDX_W-1:0] col_index;
    logic signed [VAL_W-1:0] element_value;

    modport source (output valid, cmd, row_sel, col_index, element_value, input ready);
    modport sink   (input valid, cmd, row_sel, col_index, element_value, output ready);
endinterface

interface mme_out_if import mme_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] out_row;
    logic [IDX_W-1:0] out_col;
    logic signed [DOT_W-1:0] dot_value;
    logic             last;

    modport source (output valid, out_row, out_col, dot_value, last, input ready);
    modport sink   (input valid, out_row, out_col, dot_value, last, output ready);
endinterface

interface mme_cfg_if import mme_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CFG_A_W-1:0] index;
    logic [DIM_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/mme_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ design/matrix_multiply_engine.sv @@
// Top level of the fixed-point matrix multiply engine.
//
// Usage: an input word on i_in carries a command. CMD_WRITE_A and CMD_WRITE_B
// store one signed Q8.8 element at (row_sel, col_index) of matrix A or B;
// writes outside MAX_DIM x MAX_DIM are dropped. CMD_COMPUTE emits every entry
// of A x B in row-major order on o_out, each word carrying its row, column,
// the exact Q.16 sum of products and a last flag on the final entry.
// Dimensions come from three registers written over i_cfg (index 0 rows of A,
// 1 shared dimension, 2 columns of B); zero reads as 1 and large values clamp
// to MAX_DIM. The configuration channel is always ready.
// Throughput: writes are taken one per cycle while the engine is idle. A
// compute word blocks the input until all rows * cols * shared_dim store
// reads are issued, one per cycle unless the receiver stalls; the single
// multiply-accumulate unit fed by one read port of each store sets this.
// Each read passes the store read register, the product register and the
// accumulator; the result register loads on the last product of each entry,
// and the last result may still be pending once the input is ready again.
// Reset clears the control state and sets all dimensions to 8; stores are not
// cleared. While the receiver stalls with a result pending, the whole
// read/multiply pipeline freezes and resumes without loss once it is taken.
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply_engine import mme_pkg::*; #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mme_in_if.sink    i_in,
    mme_out_if.source o_out,
    mme_cfg_if.sink   i_cfg
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = 2 * ELEM_WIDTH;
    // Eight products at most, so three guard bits keep the sum exact.
    localparam int ACCW  = PW + 3;

    typedef enum logic {S_IDLE, S_RUN} t_state;

    // Configuration registers.
    logic [DIM_W-1:0] r_a_rows, r_shared_dim, r_b_cols;

    // Sequencer state and loop counters.
    t_state           r_state;
    logic [IDX_W-1:0] r_r, r_c, r_k;

    // Pipeline: store read, product, accumulate into result register.
    logic                    r_s1_valid, r_s2_valid;
    t_tag                    r_s1_tag, r_s2_tag;
    logic signed [PW-1:0]    r_prod;
    logic signed [ACCW-1:0]  r_acc;
    logic                    r_out_valid;
    logic [IDX_W-1:0]        r_out_row, r_out_col;
    logic signed [DOT_W-1:0] r_out_dot;
    logic                    r_out_last;

    logic                    in_accept, stall, issue, in_range, out_load;
    logic [DIM_W-1:0]        nr, nk, nc;
    logic                    k_end, c_end, r_end;
    t_tag                    n_tag;
    logic [AW-1:0]           waddr, a_raddr, b_raddr;
    logic                    we_a, we_b;
    logic [ELEM_WIDTH-1:0]   wdata, a_rdata, b_rdata;
    logic signed [ACCW-1:0]  n_sum;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = v;
        end
        return res;
    endfunction

    assign nr = eff_dim(r_a_rows);
    assign nk = eff_dim(r_shared_dim);
    assign nc = eff_dim(r_b_cols);

    // Configuration port.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows     <= DIM_RESET;
            r_shared_dim <= DIM_RESET;
            r_b_cols     <= DIM_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_A_ROWS:     r_a_rows     <= i_cfg.data;
                REG_SHARED_DIM: r_shared_dim <= i_cfg.data;
                REG_B_COLS:     r_b_cols     <= i_cfg.data;
                default:        ;
            endcase
        end
    end

    // Element writes go straight into the stores.
    assign in_accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign in_range  = ({1'b0, i_in.row_sel} < DIM_W'(MAX_DIM)) &&
                       ({1'b0, i_in.col_index} < DIM_W'(MAX_DIM));
    assign we_a  = in_accept && in_range && (i_in.cmd == CMD_WRITE_A);
    assign we_b  = in_accept && in_range && (i_in.cmd == CMD_WRITE_B);
    assign waddr = AW'(int'(i_in.row_sel) * MAX_DIM + int'(i_in.col_index));
    assign wdata = ELEM_WIDTH'(i_in.element_value);

    // The pipeline freezes while a finished result waits for the receiver.
    assign stall = r_out_valid && !o_out.ready;
    assign issue = (r_state == S_RUN) && !stall;

    assign k_end = ({1'b0, r_k} == nk - DIM_W'(1));
    assign c_end = ({1'b0, r_c} == nc - DIM_W'(1));
    assign r_end = ({1'b0, r_r} == nr - DIM_W'(1));

    assign a_raddr = AW'(int'(r_r) * MAX_DIM + int'(r_k));
    assign b_raddr = AW'(int'(r_k) * MAX_DIM + int'(r_c));

    always_comb begin
        n_tag.first      = (r_k == '0);
        n_tag.last_k     = k_end;
        n_tag.last_entry = k_end && c_end && r_end;
        n_tag.row        = r_r;
        n_tag.col        = r_c;
    end

    // Sequencer: walks row, column and shared index, one store read per cycle while the receiver does not stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_r     <= '0;
            r_c     <= '0;
            r_k     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_accept && (i_in.cmd == CMD_COMPUTE)) begin
                        r_state <= S_RUN;
                        r_r     <= '0;
                        r_c     <= '0;
                        r_k     <= '0;
                    end
                end
                S_RUN: begin
                    if (issue) begin
                        if (!k_end) begin
                            r_k <= r_k + IDX_W'(1);
                        end else begin
                            r_k <= '0;
                            if (!c_end) begin
                                r_c <= r_c + IDX_W'(1);
                            end else begin
                                r_c <= '0;
                                if (!r_end) begin
                                    r_r <= r_r + IDX_W'(1);
                                end else begin
                                    r_state <= S_IDLE;
                                end
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    mme_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (!stall),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    mme_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (!stall),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    // Valid bits of the pipeline stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (!stall) begin
            r_s1_valid  <= issue;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= out_load;
        end
    end

    // The first product of an entry restarts the sum.
    assign n_sum    = (r_s2_tag.first ? ACCW'(0) : r_acc) + ACCW'(r_prod);
    assign out_load = r_s2_valid && r_s2_tag.last_k;

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_s1_tag <= n_tag;
            r_s2_tag <= r_s1_tag;
            r_prod   <= PW'($signed(a_rdata) * $signed(b_rdata));
            if (r_s2_valid) begin
                r_acc <= n_sum;
            end
            if (out_load) begin
                r_out_row  <= r_s2_tag.row;
                r_out_col  <= r_s2_tag.col;
                r_out_dot  <= DOT_W'(n_sum);
                r_out_last <= r_s2_tag.last_entry;
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_row   = r_out_row;
    assign o_out.out_col   = r_out_col;
    assign o_out.dot_value = r_out_dot;
    assign o_out.last      = r_out_last;

    // The input is held off for the whole sweep of a compute command.
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> !i_in.ready)
        else $error("input ready while a product is being computed");

    // The shared-index counter never leaves the configured range.
    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> ({1'b0, r_k} < nk))
        else $error("shared index counter out of range");

    // A stalled receiver freezes the store-read and product stages.
    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stall && i_rst_n) |=> ($stable(r_s1_valid) && $stable(r_s2_valid)))
        else $error("pipeline advanced while the result word was stalled");

    // The final entry of a product always closes a dot product.
    a_last_closes_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_tag.last_entry) |-> r_s1_tag.last_k)
        else $error("last entry marked before its dot product is complete");

endmodule

`default_nettype wire
